// ----- rtl/keyed_timeout_table_core_assert.svh -----
// Assertion macros used by the keyed timeout table core.
`ifndef KEYED_TIMEOUT_TABLE_CORE_ASSERT_SVH
`define KEYED_TIMEOUT_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on the rising clock edge, switched off while reset is applied.
`define KTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define KTT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTT_ASSERT(label, clk, rst_n, prop, msg)
`define KTT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/ktt_pkg.sv -----
// Types and constants of the keyed timeout table.
package ktt_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int CMD_W         = 3;
    localparam int KEY_W         = 64;
    localparam int STAMP_W       = 32;
    localparam int TIMEOUT_W     = 16;
    localparam int KIND_W        = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd5;

    localparam logic [KIND_W-1:0] EV_TIMEOUT = 2'd0;
    localparam logic [KIND_W-1:0] EV_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] EV_MISSING = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Strobes from the controller to the entry memory.
    typedef struct packed {
        logic rd_en;
        logic wr_key_en;
        logic wr_stamp_en;
    } ram_ctl_t;

endpackage

// ----- rtl/ktt_entry_ram.sv -----
// Entry memory of the keyed timeout table: stored keys and stamps.
module ktt_entry_ram #(
    parameter int DEPTH  = ktt_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  ktt_pkg::ram_ctl_t            ctl,
    input  logic [ADDR_W-1:0]            rd_addr,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [ktt_pkg::KEY_W-1:0]    wr_key,
    input  logic [ktt_pkg::STAMP_W-1:0]  wr_stamp,
    output logic [ktt_pkg::KEY_W-1:0]    rd_key,
    output logic [ktt_pkg::STAMP_W-1:0]  rd_stamp
);

    logic [ktt_pkg::KEY_W-1:0]   key_mem   [DEPTH];
    logic [ktt_pkg::STAMP_W-1:0] stamp_mem [DEPTH];

    // Keys and stamps share one address; each half has its own write strobe.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_key_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (ctl.wr_stamp_en)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/keyed_timeout_table_core.sv -----
// Top level of the keyed timeout table: command decode, scan control and result output.
//
// The keyed timeout table holds up to DEPTH 64-bit keys, each stamped with the
// second at which it was last seen, and keeps its own seconds counter that
// advances by one on every tick command. A command word is taken at a rising
// clock edge where start is high and busy is low. Tick and clear finish in the
// cycle they are taken and leave busy low. Add, refresh, remove and check
// each hold busy high for a scan: the entry memory has one read port, so the
// scan reads one slot per cycle, then the compare stage drains and the done
// state of the controller writes the table back. Codes 6 and 7
// are taken and ignored. Results leave on event_kind, event_key and
// last_of_run, each word valid for exactly one cycle while result_valid is
// high; the receiver cannot hold results off, so it must take every word in
// that cycle. A check returns one timed-out word per expired entry in slot
// order, and the last of them carries last_of_run. A full-table add and a
// refresh of a missing key return a single word with last_of_run set. The
// timeout register is written through cfg_wr_en and cfg_wr_data and should
// only be changed while busy is low; the host is expected to issue a check
// about every five seconds, though the block does not rely on that.
module keyed_timeout_table_core #(
    parameter int DEPTH = ktt_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ktt_pkg::CMD_W-1:0]      command,
    input  logic [ktt_pkg::KEY_W-1:0]      entry_key,
    input  logic                           cfg_wr_en,
    input  logic [ktt_pkg::TIMEOUT_W-1:0]  cfg_wr_data,
    output logic                           result_valid,
    output logic [ktt_pkg::KIND_W-1:0]     event_kind,
    output logic [ktt_pkg::KEY_W-1:0]      event_key,
    output logic                           last_of_run
);

    `include "keyed_timeout_table_core_assert.svh"

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(DEPTH);

    // Controller state.
    ktt_pkg::state_t state_reg, state_next;

    // Command latched for the duration of a scan.
    logic [ktt_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [ktt_pkg::KEY_W-1:0] key_reg, key_next;

    // Table bookkeeping kept in flip-flops.
    logic [DEPTH-1:0]              valid_reg, valid_next;
    logic [ktt_pkg::STAMP_W-1:0]   seconds_reg, seconds_next;
    logic [ktt_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;

    // Scan pipeline: issue counter and the compare stage behind the memory read.
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    // Results of the search.
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // An expired entry waits here until the scan shows whether it is the last.
    logic                      pend_vld_reg, pend_vld_next;
    logic [ktt_pkg::KEY_W-1:0] pend_key_reg, pend_key_next;

    // Registered result word.
    logic                       res_vld_reg, res_vld_next;
    logic [ktt_pkg::KIND_W-1:0] res_kind_reg, res_kind_next;
    logic [ktt_pkg::KEY_W-1:0]  res_key_reg, res_key_next;
    logic                       res_last_reg, res_last_next;

    // Memory interface.
    ktt_pkg::ram_ctl_t           ram_ctl;
    logic [IDX_W-1:0]            wr_addr;
    logic [ktt_pkg::KEY_W-1:0]   rd_key;
    logic [ktt_pkg::STAMP_W-1:0] rd_stamp;

    // Compare-stage decisions.
    logic                        accept;
    logic                        slot_valid;
    logic [ktt_pkg::STAMP_W-1:0] age;
    logic                        is_hit;
    logic                        is_free;
    logic                        is_expired;
    logic                        scan_end;
    logic                        add_write;
    logic                        refresh_write;

    assign accept     = start && !busy;
    assign slot_valid = valid_reg[cmp_idx_reg];
    assign age        = seconds_reg - rd_stamp;
    assign is_hit     = cmp_vld_reg && slot_valid && (rd_key == key_reg);
    assign is_free    = cmp_vld_reg && !slot_valid;
    assign is_expired = cmp_vld_reg && slot_valid && (cmd_reg == ktt_pkg::CMD_CHECK)
                        && (age > {{(ktt_pkg::STAMP_W - ktt_pkg::TIMEOUT_W){1'b0}}, timeout_reg});
    assign scan_end   = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);

    // An add writes only a key that is absent and only when a slot is free.
    assign add_write     = (state_reg == ktt_pkg::ST_DONE) && (cmd_reg == ktt_pkg::CMD_ADD)
                           && !hit_found_reg && free_found_reg;
    assign refresh_write = (state_reg == ktt_pkg::ST_DONE) && (cmd_reg == ktt_pkg::CMD_REFRESH)
                           && hit_found_reg;
    assign wr_addr       = (cmd_reg == ktt_pkg::CMD_ADD) ? free_idx_reg : hit_idx_reg;

    ktt_entry_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_entry_ram (
        .clk      (clk),
        .ctl      (ram_ctl),
        .rd_addr  (issue_cnt_reg[IDX_W-1:0]),
        .wr_addr  (wr_addr),
        .wr_key   (key_reg),
        .wr_stamp (seconds_reg),
        .rd_key   (rd_key),
        .rd_stamp (rd_stamp)
    );

    // Next state of the controller.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ktt_pkg::ST_IDLE:
            begin
                if (accept && (command == ktt_pkg::CMD_ADD || command == ktt_pkg::CMD_REFRESH
                               || command == ktt_pkg::CMD_REMOVE
                               || command == ktt_pkg::CMD_CHECK))
                begin
                    state_next = ktt_pkg::ST_SCAN;
                end
            end
            ktt_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ktt_pkg::ST_DONE;
                end
            end
            ktt_pkg::ST_DONE:
            begin
                state_next = ktt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ktt_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        busy              = (state_reg != ktt_pkg::ST_IDLE);
        ram_ctl.rd_en     = (state_reg == ktt_pkg::ST_SCAN) && (issue_cnt_reg < CNT_END);
        ram_ctl.wr_key_en = add_write;
        ram_ctl.wr_stamp_en = add_write || refresh_write;
    end

    // Datapath next values.
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        valid_next      = valid_reg;
        seconds_next    = seconds_reg;
        timeout_next    = timeout_reg;
        issue_cnt_next  = issue_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_vld_next   = pend_vld_reg;
        pend_key_next   = pend_key_reg;
        res_vld_next    = 1'b0;
        res_kind_next   = res_kind_reg;
        res_key_next    = res_key_reg;
        res_last_next   = res_last_reg;

        if (cfg_wr_en)
        begin
            timeout_next = cfg_wr_data;
        end

        unique case (state_reg)
            ktt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = command;
                    key_next        = entry_key;
                    issue_cnt_next  = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    pend_vld_next   = 1'b0;
                    unique case (command)
                        ktt_pkg::CMD_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        ktt_pkg::CMD_TICK:
                        begin
                            seconds_next = seconds_reg + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ktt_pkg::ST_SCAN:
            begin
                if (ram_ctl.rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = issue_cnt_reg[IDX_W-1:0];
                end
                if (is_hit && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                end
                if (is_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                // A newly expired entry pushes out the one before it, which
                // is then known not to be the last of the run.
                if (is_expired)
                begin
                    valid_next[cmp_idx_reg] = 1'b0;
                    pend_vld_next = 1'b1;
                    pend_key_next = rd_key;
                    if (pend_vld_reg)
                    begin
                        res_vld_next  = 1'b1;
                        res_kind_next = ktt_pkg::EV_TIMEOUT;
                        res_key_next  = pend_key_reg;
                        res_last_next = 1'b0;
                    end
                end
            end
            ktt_pkg::ST_DONE:
            begin
                unique case (cmd_reg)
                    ktt_pkg::CMD_ADD:
                    begin
                        if (!hit_found_reg)
                        begin
                            if (free_found_reg)
                            begin
                                valid_next[free_idx_reg] = 1'b1;
                            end
                            else
                            begin
                                res_vld_next  = 1'b1;
                                res_kind_next = ktt_pkg::EV_FULL;
                                res_key_next  = key_reg;
                                res_last_next = 1'b1;
                            end
                        end
                    end
                    ktt_pkg::CMD_REFRESH:
                    begin
                        if (!hit_found_reg)
                        begin
                            res_vld_next  = 1'b1;
                            res_kind_next = ktt_pkg::EV_MISSING;
                            res_key_next  = key_reg;
                            res_last_next = 1'b1;
                        end
                    end
                    ktt_pkg::CMD_REMOVE:
                    begin
                        if (hit_found_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                    end
                    ktt_pkg::CMD_CHECK:
                    begin
                        if (pend_vld_reg)
                        begin
                            res_vld_next  = 1'b1;
                            res_kind_next = ktt_pkg::EV_TIMEOUT;
                            res_key_next  = pend_key_reg;
                            res_last_next = 1'b1;
                        end
                        pend_vld_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ktt_pkg::ST_IDLE;
            valid_reg      <= '0;
            seconds_reg    <= '0;
            timeout_reg    <= ktt_pkg::TIMEOUT_RESET;
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            seconds_reg    <= seconds_next;
            timeout_reg    <= timeout_next;
            issue_cnt_reg  <= issue_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            pend_vld_reg   <= pend_vld_next;
            res_vld_reg    <= res_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_key_reg  <= pend_key_next;
        res_kind_reg  <= res_kind_next;
        res_key_reg   <= res_key_next;
        res_last_reg  <= res_last_next;
    end

    assign result_valid = res_vld_reg;
    assign event_kind   = res_kind_reg;
    assign event_key    = res_key_reg;
    assign last_of_run  = res_last_reg;

    // The compare stage only ever holds a slot while a scan is running.
    `KTT_ASSERT_ALWAYS(a_idle_pipe_empty, clk, !busy |-> !cmp_vld_reg, "compare stage busy while idle")
    // The last word of a run is never followed at once by another word.
    `KTT_ASSERT(a_last_then_gap, clk, rst_n, result_valid && last_of_run |=> !result_valid, "word right after last of run")
    // Full-table and missing-key words stand alone.
    `KTT_ASSERT(a_single_event_last, clk, rst_n, result_valid && event_kind != ktt_pkg::EV_TIMEOUT |-> last_of_run, "single event word without last flag")
    // A check starts a scan.
    `KTT_ASSERT(a_check_scans, clk, rst_n, start && !busy && command == ktt_pkg::CMD_CHECK |=> busy, "check did not start a scan")
    // The memory is never read and written in the same cycle.
    `KTT_ASSERT(a_ram_no_overlap, clk, rst_n, ram_ctl.rd_en |-> !ram_ctl.wr_stamp_en, "entry memory read and written together")

endmodule

// ----- bench/keyed_timeout_table_core_tb.sv -----
// Self-checking bench for the keyed timeout table core: directed cases, random phases, scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
    logic [ktt_pkg::KIND_W-1:0] kind;
    logic [ktt_pkg::KEY_W-1:0]  key;
    logic                       last;
} table_event_t;

// Shadow copy of the aging table plus the queue of events it says must come out.
class aging_table_shadow;
    logic [ktt_pkg::KEY_W-1:0]     keys[ktt_pkg::DEPTH_DEFAULT];
    logic [ktt_pkg::STAMP_W-1:0]   stamps[ktt_pkg::DEPTH_DEFAULT];
    bit                            occupied[ktt_pkg::DEPTH_DEFAULT];
    logic [ktt_pkg::STAMP_W-1:0]   seconds;
    logic [ktt_pkg::TIMEOUT_W-1:0] timeout;
    table_event_t                  awaited[$];
    int                            mismatches;
    int                            events_seen;

    function new();
        seconds     = '0;
        timeout     = ktt_pkg::TIMEOUT_RESET;
        mismatches  = 0;
        events_seen = 0;
        foreach (occupied[i])
            occupied[i] = 1'b0;
    endfunction

    function void set_timeout(logic [ktt_pkg::TIMEOUT_W-1:0] value);
        timeout = value;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function int slot_of(logic [ktt_pkg::KEY_W-1:0] key);
        for (int i = 0; i < ktt_pkg::DEPTH_DEFAULT; i++)
            if (occupied[i] && keys[i] == key)
                return i;
        return -1;
    endfunction

    function int first_free();
        for (int i = 0; i < ktt_pkg::DEPTH_DEFAULT; i++)
            if (!occupied[i])
                return i;
        return -1;
    endfunction

    function table_event_t make_event(logic [ktt_pkg::KIND_W-1:0] kind,
                                      logic [ktt_pkg::KEY_W-1:0] key, logic last);
        table_event_t ev;
        ev.kind = kind;
        ev.key  = key;
        ev.last = last;
        return ev;
    endfunction

    // Applies one accepted command word and queues the events it causes.
    function void apply_command(logic [ktt_pkg::CMD_W-1:0] cmd, logic [ktt_pkg::KEY_W-1:0] key);
        int                          slot;
        logic [ktt_pkg::STAMP_W-1:0] age;
        table_event_t                held;
        bit                          have_held;
        have_held = 1'b0;
        held      = '0;
        case (cmd)
            ktt_pkg::CMD_ADD:
            begin
                if (slot_of(key) < 0)
                begin
                    slot = first_free();
                    if (slot < 0)
                        awaited.push_back(make_event(ktt_pkg::EV_FULL, key, 1'b1));
                    else
                    begin
                        keys[slot]     = key;
                        stamps[slot]   = seconds;
                        occupied[slot] = 1'b1;
                    end
                end
            end
            ktt_pkg::CMD_REFRESH:
            begin
                slot = slot_of(key);
                if (slot < 0)
                    awaited.push_back(make_event(ktt_pkg::EV_MISSING, key, 1'b1));
                else
                    stamps[slot] = seconds;
            end
            ktt_pkg::CMD_REMOVE:
            begin
                slot = slot_of(key);
                if (slot >= 0)
                    occupied[slot] = 1'b0;
            end
            ktt_pkg::CMD_CLEAR:
            begin
                foreach (occupied[i])
                    occupied[i] = 1'b0;
            end
            ktt_pkg::CMD_TICK:
                seconds = seconds + 1'b1;
            ktt_pkg::CMD_CHECK:
            begin
                for (int i = 0; i < ktt_pkg::DEPTH_DEFAULT; i++)
                begin
                    age = seconds - stamps[i];
                    if (occupied[i] && age > timeout)
                    begin
                        occupied[i] = 1'b0;
                        if (have_held)
                            awaited.push_back(held);
                        held      = make_event(ktt_pkg::EV_TIMEOUT, keys[i], 1'b0);
                        have_held = 1'b1;
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    awaited.push_back(held);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Compares one event word from the block against the oldest expected event.
    task compare_event(logic [ktt_pkg::KIND_W-1:0] kind, logic [ktt_pkg::KEY_W-1:0] key,
                       logic last);
        table_event_t want;
        events_seen++;
        if (awaited.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected word kind %0d key %h last %0b", kind, key, last));
            return;
        end
        want = awaited.pop_front();
        if (kind !== want.kind)
            flag_mismatch($sformatf("event_kind %0d, expected %0d", kind, want.kind));
        if (key !== want.key)
            flag_mismatch($sformatf("event_key %h, expected %h", key, want.key));
        if (last !== want.last)
            flag_mismatch($sformatf("last_of_run %0b, expected %0b", last, want.last));
    endtask
endclass

module keyed_timeout_table_core_tb;

    localparam int DEPTH         = ktt_pkg::DEPTH_DEFAULT;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int POOL_SIZE     = 48;
    localparam int PHASES        = 6;
    localparam int RANDOM_WORDS  = 138;
    localparam int WANTED_EVENTS = 48;
    localparam int EXTRA_WORDS   = 300;

    // Command codes the block takes and then ignores.
    localparam logic [ktt_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [ktt_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic                          clk;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic [ktt_pkg::CMD_W-1:0]     command     = ktt_pkg::CMD_ADD;
    logic [ktt_pkg::KEY_W-1:0]     entry_key   = '0;
    logic                          cfg_wr_en   = 1'b0;
    logic [ktt_pkg::TIMEOUT_W-1:0] cfg_wr_data = '0;
    logic                          busy;
    logic                          result_valid;
    logic [ktt_pkg::KIND_W-1:0]    event_kind;
    logic [ktt_pkg::KEY_W-1:0]     event_key;
    logic                          last_of_run;

    int                            cycle_count = 0;
    logic [ktt_pkg::KEY_W-1:0]     key_pool[POOL_SIZE];
    int                            pool_span;
    bit                            allow_gaps;
    aging_table_shadow             shadow;

    keyed_timeout_table_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .entry_key   (entry_key),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result_valid(result_valid),
        .event_kind  (event_kind),
        .event_key   (event_key),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing event word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("keyed_timeout_table_core regression: fail");
            $finish;
        end
    end

    // The receiver cannot stall, so every strobed word is taken at the edge that
    // ends its cycle. Values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            shadow.compare_event(event_kind, event_key, last_of_run);
    end

    // Presents one command word and holds it until the block takes it. Start is
    // left high on return so that back-to-back words need no second assignment
    // in the same step; a random gap lowers it first when gaps are allowed.
    task send_word(logic [ktt_pkg::CMD_W-1:0] cmd, logic [ktt_pkg::KEY_W-1:0] key);
        start     <= 1'b1;
        command   <= cmd;
        entry_key <= key;
        do
            @(posedge clk);
        while (busy);
        shadow.apply_command(cmd, key);
        if (allow_gaps && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Holds the sender off until every expected word has come back. Successful adds,
    // removes and quiet checks produce nothing yet keep busy high through their scan,
    // so the task then also waits for busy to fall before the block counts as idle.
    task wait_idle();
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Only ever called right after wait_idle, so the block is quiet.
    task write_timeout(logic [ktt_pkg::TIMEOUT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow.set_timeout(value);
    endtask

    // One random word. Most traffic is add, refresh, tick and check over a key
    // pool so entries live, age and expire; the rest is removes, clears, unused
    // codes and keys the table has never seen.
    task random_word();
        int                        pick;
        logic [ktt_pkg::CMD_W-1:0] cmd;
        logic [ktt_pkg::KEY_W-1:0] key;
        pick = $urandom_range(99);
        if (pick < 30)
            cmd = ktt_pkg::CMD_ADD;
        else if (pick < 45)
            cmd = ktt_pkg::CMD_REFRESH;
        else if (pick < 55)
            cmd = ktt_pkg::CMD_REMOVE;
        else if (pick < 75)
            cmd = ktt_pkg::CMD_TICK;
        else if (pick < 90)
            cmd = ktt_pkg::CMD_CHECK;
        else if (pick < 93)
            cmd = ktt_pkg::CMD_CLEAR;
        else if (pick < 96)
            cmd = CMD_SPARE_LO;
        else
            cmd = CMD_SPARE_HI;
        if ($urandom_range(9) == 0)
            key = {$urandom, $urandom};
        else
            key = key_pool[$urandom_range(pool_span - 1)];
        send_word(cmd, key);
    endtask

    initial
    begin
        int phase_timeouts[PHASES];
        int extra;
        phase_timeouts = '{16'hFFFF, 1, 0, 3, 2, 5};
        shadow     = new();
        allow_gaps = 1'b1;
        pool_span  = POOL_SIZE;

        // The two extreme keys sit at the front of the pool; the rest are random.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Basic commands under the reset timeout of 30 seconds: a refresh of an
        // empty table, a duplicate add, a remove of an absent key, a quiet check,
        // and the two unused codes.
        send_word(ktt_pkg::CMD_REFRESH, key_pool[0]);
        send_word(ktt_pkg::CMD_ADD, key_pool[0]);
        send_word(ktt_pkg::CMD_ADD, key_pool[1]);
        send_word(ktt_pkg::CMD_ADD, key_pool[1]);
        send_word(ktt_pkg::CMD_REFRESH, key_pool[1]);
        send_word(ktt_pkg::CMD_REMOVE, key_pool[2]);
        send_word(ktt_pkg::CMD_CHECK, key_pool[1]);
        send_word(CMD_SPARE_LO, key_pool[1]);
        send_word(CMD_SPARE_HI, key_pool[0]);

        // An age equal to the timeout must survive; one tick later both expire.
        repeat (30) send_word(ktt_pkg::CMD_TICK, key_pool[3]);
        send_word(ktt_pkg::CMD_CHECK, key_pool[0]);
        send_word(ktt_pkg::CMD_TICK, key_pool[1]);
        send_word(ktt_pkg::CMD_CHECK, key_pool[0]);

        // Clear wipes live entries, so the following refresh misses.
        send_word(ktt_pkg::CMD_ADD, key_pool[0]);
        send_word(ktt_pkg::CMD_CLEAR, key_pool[1]);
        send_word(ktt_pkg::CMD_CHECK, key_pool[1]);
        send_word(ktt_pkg::CMD_REFRESH, key_pool[0]);

        // Fill every slot, then push past full: a rejected add, a duplicate add
        // into a full table, a remove that frees a middle slot and an add that
        // must land there. With a zero timeout a single tick expires all DEPTH
        // entries in one check.
        wait_idle();
        write_timeout('0);
        for (int i = 2; i < DEPTH + 2; i++)
            send_word(ktt_pkg::CMD_ADD, key_pool[i]);
        send_word(ktt_pkg::CMD_ADD, key_pool[DEPTH + 2]);
        send_word(ktt_pkg::CMD_ADD, key_pool[2]);
        send_word(ktt_pkg::CMD_REMOVE, key_pool[5]);
        send_word(ktt_pkg::CMD_ADD, key_pool[DEPTH + 2]);
        send_word(ktt_pkg::CMD_REFRESH, key_pool[DEPTH + 3]);
        send_word(ktt_pkg::CMD_TICK, key_pool[0]);
        send_word(ktt_pkg::CMD_CHECK, key_pool[0]);

        // Random phases, each under its own timeout. A small key pool keeps adds
        // and refreshes hitting live entries; the full pool drives misses. The
        // last phase runs with no sender gaps and keeps going until enough
        // event words have come back or EXTRA_WORDS more words have gone out.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            write_timeout(ktt_pkg::TIMEOUT_W'(phase_timeouts[phase]));
            pool_span  = ($urandom_range(1) == 0) ? 8 : POOL_SIZE;
            allow_gaps = (phase < PHASES - 1);
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++)
                random_word();
        end
        extra = 0;
        while (shadow.events_seen < WANTED_EVENTS && extra < EXTRA_WORDS)
        begin
            random_word();
            extra++;
        end

        wait_idle();
        if (shadow.mismatches == 0)
            $display("keyed_timeout_table_core regression: pass");
        else
            $display("keyed_timeout_table_core regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ktt_pkg.sv
rtl/ktt_entry_ram.sv
rtl/keyed_timeout_table_core.sv
bench/keyed_timeout_table_core_tb.sv
